FILE: rtl/core/sae_pkg.sv
// Shared types, constants and AES helper functions for the frame encryptor.
package sae_pkg;

	localparam int unsigned BLK_BYTES = 16;
	localparam int unsigned LEAD_BYTES = 16;
	localparam int unsigned MAX_FRAME_BYTES = 65535;
	localparam int unsigned FIFO_DEPTH = 4;
	localparam int unsigned FIFO_AW = $clog2(FIFO_DEPTH);

	localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
	localparam logic [1:0] CFG_KEY_LOW = 2'd1;
	localparam logic [1:0] CFG_IV_HIGH = 2'd2;
	localparam logic [1:0] CFG_IV_LOW = 2'd3;

	typedef struct packed {
		logic [127:0] key;
		logic [127:0] iv;
	} sae_cfg_t;

	// One queued job: a clear byte (in data[127:120]) or a full block.
	typedef struct packed {
		logic         is_block;
		logic         first;
		logic         frame_end;
		logic [127:0] data;
	} sae_job_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] xtime(input logic [7:0] x);
		xtime = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] rcon(input logic [3:0] rnd);
		case (rnd)
			4'd1:    rcon = 8'h01;
			4'd2:    rcon = 8'h02;
			4'd3:    rcon = 8'h04;
			4'd4:    rcon = 8'h08;
			4'd5:    rcon = 8'h10;
			4'd6:    rcon = 8'h20;
			4'd7:    rcon = 8'h40;
			4'd8:    rcon = 8'h80;
			4'd9:    rcon = 8'h1b;
			4'd10:   rcon = 8'h36;
			default: rcon = 8'h00;
		endcase
	endfunction

endpackage

FILE: rtl/core/sae_in_if.sv
// Input channel: frame bytes with start flag and frame length.
interface sae_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  in_byte;
	logic        frame_start;
	logic [15:0] frame_length;

	modport source (output valid, in_byte, frame_start, frame_length, input ready);
	modport sink (input valid, in_byte, frame_start, frame_length, output ready);
endinterface

FILE: rtl/core/sae_out_if.sv
// Output channel: clear or encrypted bytes with run and frame markers.
interface sae_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       was_encrypted;
	logic       run_last;
	logic       frame_end;

	modport source (output valid, out_byte, was_encrypted, run_last, frame_end, input ready);
	modport sink (input valid, out_byte, was_encrypted, run_last, frame_end, output ready);
endinterface

FILE: rtl/core/sample_aes_frame_encryptor.sv
// Top level of the sample-AES frame encryptor.
// Accepts one frame byte per cycle while the job queue has room. Clear bytes
// come out one to one; encrypted bytes come out as a run of 16 once their
// block is complete, after a pass through the iterative AES round unit that
// overlaps the emission of the previous run. A four-entry job queue separates
// byte classification from the cipher and the emitter.
module sample_aes_frame_encryptor import sae_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	sae_in_if.sink      in_ch,
	sae_out_if.source   out_ch,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [63:0] cfg_data
);

	logic [63:0] key_hi_q, key_lo_q, iv_hi_q, iv_lo_q;
	sae_cfg_t    cfg;
	sae_job_t    f_job, q_job;
	logic        f_push, q_not_full, q_not_empty, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
			iv_hi_q <= '0;
			iv_lo_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_KEY_HIGH: key_hi_q <= cfg_data;
				CFG_KEY_LOW:  key_lo_q <= cfg_data;
				CFG_IV_HIGH:  iv_hi_q <= cfg_data;
				CFG_IV_LOW:   iv_lo_q <= cfg_data;
				default:      ;
			endcase
		end
	end

	assign cfg.key = {key_hi_q, key_lo_q};
	assign cfg.iv = {iv_hi_q, iv_lo_q};
	assign in_ch.ready = q_not_full;

	sae_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_ch.valid),
		.in_byte      (in_ch.in_byte),
		.frame_start  (in_ch.frame_start),
		.frame_length (in_ch.frame_length),
		.iv           (cfg.iv),
		.push_ok      (q_not_full),
		.push         (f_push),
		.job          (f_job)
	);

	sae_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.wr_job    (f_job),
		.not_full  (q_not_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rd_job    (q_job)
	);

	sae_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.key           (cfg.key),
		.job_valid     (q_not_empty),
		.job           (q_job),
		.pop           (q_pop),
		.out_valid     (out_ch.valid),
		.out_ready     (out_ch.ready),
		.out_byte      (out_ch.out_byte),
		.was_encrypted (out_ch.was_encrypted),
		.run_last      (out_ch.run_last),
		.frame_end     (out_ch.frame_end)
	);

endmodule

FILE: rtl/core/sae_front.sv
// Front end: tracks frame position, classifies bytes and gathers blocks.
module sae_front import sae_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         in_valid,
	input  logic [7:0]   in_byte,
	input  logic         frame_start,
	input  logic [15:0]  frame_length,
	input  logic [127:0] iv,
	input  logic         push_ok,
	output logic         push,
	output sae_job_t     job
);

	logic [15:0] pos_q, end_q, tot_q;
	logic        first_q;
	logic [127:0] iv_q, iv_e;
	logic [7:0]  buf_q [BLK_BYTES];
	logic [15:0] pos_e, end_e, tot_e, len_c;
	logic        first_e, is_clear, fe, acc;
	logic [127:0] blk;

	assign acc = in_valid && push_ok;

	always_comb begin
		len_c = (32'(frame_length) > MAX_FRAME_BYTES) ? 16'(MAX_FRAME_BYTES) : frame_length;
		pos_e = frame_start ? 16'd0 : pos_q;
		end_e = frame_start ? {len_c[15:4], 4'd0} : end_q;
		tot_e = frame_start ? len_c : tot_q;
		first_e = frame_start ? 1'b1 : first_q;
		iv_e = frame_start ? iv : iv_q;
		is_clear = (pos_e < 16'(LEAD_BYTES)) || (pos_e >= end_e);
		fe = ({1'b0, pos_e} + 17'd1) == {1'b0, tot_e};
		for (int i = 0; i < 15; i++) begin
			blk[127 - 8*i -: 8] = buf_q[i];
		end
		blk[7:0] = in_byte;
	end

	// the IV taken at frame start is folded into the first block of the frame
	always_comb begin
		push = acc && (is_clear || (pos_e[3:0] == 4'hf));
		job.is_block = !is_clear;
		job.first = first_e;
		job.frame_end = fe;
		job.data = is_clear ? {in_byte, 120'd0} : (first_e ? (blk ^ iv_e) : blk);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			end_q <= '0;
			tot_q <= '0;
			first_q <= 1'b0;
			iv_q <= '0;
		end else if (acc) begin
			pos_q <= (pos_e == 16'hffff) ? pos_e : pos_e + 16'd1;
			end_q <= end_e;
			tot_q <= tot_e;
			first_q <= (!is_clear && pos_e[3:0] == 4'hf) ? 1'b0 : first_e;
			iv_q <= iv_e;
		end
	end

	always_ff @(posedge clk) begin
		if (acc && !is_clear) begin
			buf_q[pos_e[3:0]] <= in_byte;
		end
	end

endmodule

FILE: rtl/core/sae_fifo.sv
// Short job queue between front end and cipher back end.
module sae_fifo import sae_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  sae_job_t wr_job,
	output logic     not_full,
	input  logic     pop,
	output logic     not_empty,
	output sae_job_t rd_job
);

	sae_job_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wp_q, rp_q;
	logic [FIFO_AW:0]   cnt_q;

	assign not_full = cnt_q != (FIFO_AW+1)'(FIFO_DEPTH);
	assign not_empty = cnt_q != '0;
	assign rd_job = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wr_job;
	end

endmodule

FILE: rtl/core/sae_back.sv
// Back end: iterative AES-128-CBC round unit and byte emitter.
module sae_back import sae_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic [127:0] key,
	input  logic     job_valid,
	input  sae_job_t job,
	output logic     pop,
	output logic     out_valid,
	input  logic     out_ready,
	output logic [7:0] out_byte,
	output logic     was_encrypted,
	output logic     run_last,
	output logic     frame_end
);

	logic         full_q, run_q, blk_q, fe_q;
	logic [3:0]   rnd_q;
	logic [127:0] st_q, rk_q, chain_q;
	logic [127:0] emit_q;
	logic [4:0]   cnt_q;
	logic         enc_s2, fe_s2;
	logic         done, load, xfer;
	logic [127:0] nrk, sb, sr, mc, nst, pre;
	logic [31:0]  tmp;

	// Key schedule step, one cipher round and the chained, key-whitened block input
	always_comb begin
		tmp = {SBOX[rk_q[23:16]] ^ rcon(rnd_q), SBOX[rk_q[15:8]],
			SBOX[rk_q[7:0]], SBOX[rk_q[31:24]]};
		nrk[127:96] = rk_q[127:96] ^ tmp;
		nrk[95:64] = rk_q[95:64] ^ nrk[127:96];
		nrk[63:32] = rk_q[63:32] ^ nrk[95:64];
		nrk[31:0] = rk_q[31:0] ^ nrk[63:32];
		for (int i = 0; i < 16; i++) begin
			sb[127 - 8*i -: 8] = SBOX[st_q[127 - 8*i -: 8]];
		end
		for (int c = 0; c < 4; c++) begin
			for (int j = 0; j < 4; j++) begin
				sr[127 - 8*(j + 4*c) -: 8] = sb[127 - 8*(j + 4*((c + j) % 4)) -: 8];
			end
		end
		for (int c = 0; c < 4; c++) begin
			logic [7:0] a0, a1, a2, a3, al;
			a0 = sr[127 - 32*c -: 8];
			a1 = sr[119 - 32*c -: 8];
			a2 = sr[111 - 32*c -: 8];
			a3 = sr[103 - 32*c -: 8];
			al = a0 ^ a1 ^ a2 ^ a3;
			mc[127 - 32*c -: 8] = a0 ^ al ^ xtime(a0 ^ a1);
			mc[119 - 32*c -: 8] = a1 ^ al ^ xtime(a1 ^ a2);
			mc[111 - 32*c -: 8] = a2 ^ al ^ xtime(a2 ^ a3);
			mc[103 - 32*c -: 8] = a3 ^ al ^ xtime(a3 ^ a0);
		end
		nst = ((rnd_q == 4'd10) ? sr : mc) ^ nrk;
		pre = (job.first ? 128'd0 : chain_q) ^ job.data ^ key;
	end

	assign done = full_q && !run_q;
	assign load = (cnt_q == 5'd0) || (cnt_q == 5'd1 && out_ready);
	assign xfer = done && load;
	assign pop = job_valid && (!full_q || xfer);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
			run_q <= 1'b0;
			rnd_q <= '0;
			chain_q <= '0;
		end else begin
			if (pop) begin
				full_q <= 1'b1;
				run_q <= job.is_block;
				rnd_q <= 4'd1;
			end else if (xfer) begin
				full_q <= 1'b0;
			end
			if (run_q) begin
				rnd_q <= rnd_q + 4'd1;
				if (rnd_q == 4'd10) begin
					run_q <= 1'b0;
					chain_q <= nst;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			st_q <= job.is_block ? pre : job.data;
			rk_q <= key;
			blk_q <= job.is_block;
			fe_q <= job.frame_end;
		end else if (run_q) begin
			st_q <= nst;
			rk_q <= nrk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (xfer) begin
			cnt_q <= blk_q ? 5'd16 : 5'd1;
		end else if (out_valid && out_ready) begin
			cnt_q <= cnt_q - 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (xfer) begin
			emit_q <= st_q;
			enc_s2 <= blk_q;
			fe_s2 <= fe_q;
		end else if (out_valid && out_ready) begin
			emit_q <= {emit_q[119:0], 8'd0};
		end
	end

	assign out_valid = cnt_q != 5'd0;
	assign out_byte = emit_q[127:120];
	assign was_encrypted = enc_s2;
	assign run_last = cnt_q == 5'd1;
	assign frame_end = fe_s2 && (cnt_q == 5'd1);

endmodule
